// ===== src/weighted_grid_cell_sampler_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the weighted grid cell sampler
// Wrappers that bind the block clock and synchronous reset.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_GRID_CELL_SAMPLER_TOP_ASSERT_SVH
`define WEIGHTED_GRID_CELL_SAMPLER_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define WGCS_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// condition must hold in the cycle after the trigger
`define WGCS_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

// condition must hold on every cycle
`define WGCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== src/wgcs_pkg.sv =====
// ---------------------------------------------------------------------------
// wgcs_pkg
// Shared widths, register indexes and control structs of the sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wgcs_pkg;

  localparam int DIM_W      = 7;
  localparam int ORG_W      = 40;
  localparam int CELL_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int COORD_W    = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int DIM_MAX    = (1 << DIM_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_EAST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_NORTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT  = 3'd5;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_ZERO_TOTAL = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]        cols;
    logic [DIM_W-1:0]        rows;
    logic signed [ORG_W-1:0] origin_east;
    logic signed [ORG_W-1:0] origin_north;
    logic [CELL_W-1:0]       cell_width;
    logic [CELL_W-1:0]       cell_height;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic walk;
    logic mul;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic zero_total;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

// ===== src/weighted_grid_cell_sampler_top.sv =====
// ---------------------------------------------------------------------------
// weighted_grid_cell_sampler_top
// Inverse-CDF cell pick over a loaded density grid, with a point in the cell.
// ---------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   load or draw request (weight, fractions; tuser kind/first)
//  m_axis    out  easting, northing; tuser status
//  cfg       in   register write (index, data)
//
// Load requests are taken back to back while idle.
// A draw walks the store up to the chosen cell index k, one store read per cycle
// (registered read), then passes through a multiply state and an output state.
// A draw with zero weight total skips the walk and multiply, going straight to output.
// Input stalls during a draw and while a result waits for an emit slot.
// Reset clears totals and the load pointer; the weight store has no reset.
`timescale 1ns / 1ps
`include "weighted_grid_cell_sampler_top_assert.svh"

module weighted_grid_cell_sampler_top #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // weight, pick, east, north fraction
  input  logic [1:0]                      s_axis_tuser,  // kind, first_weight
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [95:0]                     m_axis_tdata,  // easting, northing
  output logic [0:0]                      m_axis_tuser,  // status
  input  logic                            cfg_we,
  input  logic [wgcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wgcs_pkg::CFG_DATA_W-1:0] cfg_data
);

  wgcs_pkg::cfg_t  cfg;
  wgcs_pkg::cmd_t  cmd;
  wgcs_pkg::stat_t stat;

  logic signed [wgcs_pkg::COORD_W-1:0] easting;
  logic signed [wgcs_pkg::COORD_W-1:0] northing;
  logic                                status;

  logic draw_accept;
  logic err_out;

  wgcs_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wgcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wgcs_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .first_weight   (s_axis_tuser[1]),
    .weight         (s_axis_tdata[15:0]),
    .pick_fraction  (s_axis_tdata[31:16]),
    .east_fraction  (s_axis_tdata[47:32]),
    .north_fraction (s_axis_tdata[63:48]),
    .stat           (stat),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .easting        (easting),
    .northing       (northing),
    .status         (status)
  );

  assign m_axis_tdata = {northing, easting};
  assign m_axis_tuser = status;

  assign draw_accept = s_axis_tvalid && s_axis_tready && s_axis_tuser[0];
  assign err_out     = m_axis_tvalid && m_axis_tuser[0];

  `WGCS_ASSERT_NEXT(a_draw_walks, draw_accept && !stat.zero_total, cmd.walk, "walk not started")
  `WGCS_ASSERT_SAME(a_err_zero, err_out, m_axis_tdata == '0, "error result has coordinates")
  `WGCS_ASSERT_NEXT(a_emit_loads, cmd.emit && stat.out_free, m_axis_tvalid, "output not loaded")
  `WGCS_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "overlapping datapath commands")

endmodule

// ===== src/wgcs_cfg.sv =====
// ---------------------------------------------------------------------------
// wgcs_cfg
// Configuration registers; grid dimensions are clamped when written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgcs_cfg #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wgcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wgcs_pkg::CFG_DATA_W-1:0] cfg_data,
  output wgcs_pkg::cfg_t                  cfg
);

  localparam logic [wgcs_pkg::DIM_W-1:0] COL_CAP = (MAX_COLUMNS > wgcs_pkg::DIM_MAX) ?
    wgcs_pkg::DIM_W'(wgcs_pkg::DIM_MAX) : wgcs_pkg::DIM_W'(MAX_COLUMNS);
  localparam logic [wgcs_pkg::DIM_W-1:0] ROW_CAP = (MAX_ROWS > wgcs_pkg::DIM_MAX) ?
    wgcs_pkg::DIM_W'(wgcs_pkg::DIM_MAX) : wgcs_pkg::DIM_W'(MAX_ROWS);
  localparam logic [wgcs_pkg::DIM_W-1:0] DIM_RESET = wgcs_pkg::DIM_W'(64);
  localparam logic [wgcs_pkg::DIM_W-1:0] DIM_ONE   = wgcs_pkg::DIM_W'(1);

  function automatic logic [wgcs_pkg::DIM_W-1:0] clamp_dim(
    input logic [wgcs_pkg::DIM_W-1:0] v,
    input logic [wgcs_pkg::DIM_W-1:0] cap
  );
    logic [wgcs_pkg::DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_ONE;
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols         <= clamp_dim(DIM_RESET, COL_CAP);
      cfg.rows         <= clamp_dim(DIM_RESET, ROW_CAP);
      cfg.origin_east  <= '0;
      cfg.origin_north <= '0;
      cfg.cell_width   <= wgcs_pkg::CELL_W'(256);
      cfg.cell_height  <= wgcs_pkg::CELL_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        wgcs_pkg::CFG_GRID_COLUMNS:
          cfg.cols <= clamp_dim(cfg_data[wgcs_pkg::DIM_W-1:0], COL_CAP);
        wgcs_pkg::CFG_GRID_ROWS:
          cfg.rows <= clamp_dim(cfg_data[wgcs_pkg::DIM_W-1:0], ROW_CAP);
        wgcs_pkg::CFG_ORIGIN_EAST:  cfg.origin_east  <= cfg_data[wgcs_pkg::ORG_W-1:0];
        wgcs_pkg::CFG_ORIGIN_NORTH: cfg.origin_north <= cfg_data[wgcs_pkg::ORG_W-1:0];
        wgcs_pkg::CFG_CELL_WIDTH:   cfg.cell_width   <= cfg_data[wgcs_pkg::CELL_W-1:0];
        wgcs_pkg::CFG_CELL_HEIGHT:  cfg.cell_height  <= cfg_data[wgcs_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/wgcs_ctrl.sv =====
// ---------------------------------------------------------------------------
// wgcs_ctrl
// Request sequencer: load while idle, draw through walk, multiply, emit (zero total: emit).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgcs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  input  wgcs_pkg::stat_t stat,
  output wgcs_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_kind) begin
          state_next = stat.zero_total ? ST_EMIT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat.hit) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && in_valid && !in_kind;
  assign cmd.start = (state == ST_IDLE) && in_valid && in_kind;
  assign cmd.walk  = (state == ST_WALK);
  assign cmd.mul   = (state == ST_MUL);
  assign cmd.emit  = (state == ST_EMIT);

endmodule

// ===== src/wgcs_dp.sv =====
// ---------------------------------------------------------------------------
// wgcs_dp
// Weight store, running total, cumulative walk and coordinate arithmetic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgcs_dp #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wgcs_pkg::cmd_t                        cmd,
  input  wgcs_pkg::cfg_t                        cfg,
  input  logic                                  first_weight,
  input  logic [wgcs_pkg::FRAC_W-1:0]           weight,
  input  logic [wgcs_pkg::FRAC_W-1:0]           pick_fraction,
  input  logic [wgcs_pkg::FRAC_W-1:0]           east_fraction,
  input  logic [wgcs_pkg::FRAC_W-1:0]           north_fraction,
  output wgcs_pkg::stat_t                       stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wgcs_pkg::COORD_W-1:0]   easting,
  output logic signed [wgcs_pkg::COORD_W-1:0]   northing,
  output logic                                  status
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SW     = (WEIGHT_BITS < wgcs_pkg::FRAC_W) ? WEIGHT_BITS : wgcs_pkg::FRAC_W;
  localparam int TW     = SW + AW;
  localparam int CAPW   = 2 * wgcs_pkg::DIM_W;
  localparam int CMPW   = (CW > CAPW) ? CW : CAPW;
  localparam int FW     = wgcs_pkg::FRAC_W;
  localparam int DW     = wgcs_pkg::DIM_W;
  localparam int CLW    = wgcs_pkg::CELL_W;
  localparam int OW     = wgcs_pkg::ORG_W;
  localparam int XW     = wgcs_pkg::COORD_W;

  // store and load bookkeeping
  logic [SW-1:0]   store [DEPTH];
  logic [CW-1:0]   count;
  logic [TW-1:0]   total;
  logic [CW-1:0]   count_base;
  logic [TW-1:0]   total_base;
  logic [CAPW-1:0] cap;
  logic            wr_en;

  // walk
  logic [TW-1:0]   target;
  logic [TW-1:0]   sum;
  logic [TW-1:0]   sum_new;
  logic [CW-1:0]   rd_idx;
  logic [SW-1:0]   rd_data;
  logic            dv;
  logic            hit;
  logic            hit_now;
  logic            issue;
  logic [DW-1:0]   cur_col;
  logic [AW-1:0]   cur_row;
  logic [DW-1:0]   hit_col;
  logic [AW-1:0]   hit_row;
  logic [FW-1:0]   efr;
  logic [FW-1:0]   nfr;
  logic            err;
  logic [TW+FW-1:0] tprod;

  // products
  logic [DW+CLW-1:0] pe_cell;
  logic [AW+CLW-1:0] pn_cell;
  logic [CLW-1:0]    pe_frac;
  logic [CLW-1:0]    pn_frac;
  logic [FW+CLW-1:0] ef_prod;
  logic [FW+CLW-1:0] nf_prod;
  logic [XW-1:0]     e_sum;
  logic [XW-1:0]     n_sum;

  assign count_base = first_weight ? '0 : count;
  assign total_base = first_weight ? '0 : total;
  assign cap        = CAPW'(cfg.cols) * CAPW'(cfg.rows);
  assign wr_en      = cmd.load && (CMPW'(count_base) < CMPW'(cap)) &&
                      (CMPW'(count_base) < CMPW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
    end else if (cmd.load) begin
      count <= count_base;
      total <= total_base;
      if (wr_en) begin
        count <= count_base + CW'(1);
        total <= total_base + TW'(weight[SW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[count_base[AW-1:0]] <= weight[SW-1:0];
    end
    if (issue) begin
      rd_data <= store[rd_idx[AW-1:0]];
    end
  end

  assign tprod   = (TW+FW)'(pick_fraction) * (TW+FW)'(total);
  assign sum_new = sum + TW'(rd_data);
  assign hit_now = dv && !hit && (sum_new > target);
  assign issue   = cmd.walk && !hit && !hit_now && (rd_idx < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv  <= 1'b0;
      hit <= 1'b0;
    end else if (cmd.start) begin
      dv  <= 1'b0;
      hit <= 1'b0;
    end else begin
      dv <= issue;
      if (hit_now) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target  <= tprod[TW+FW-1:FW];
      err     <= (total == '0);
      efr     <= east_fraction;
      nfr     <= north_fraction;
      sum     <= '0;
      rd_idx  <= '0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (dv && !hit) begin
        sum <= sum_new;
        if (hit_now) begin
          hit_col <= cur_col;
          hit_row <= cur_row;
        end else if (cur_col == cfg.cols - DW'(1)) begin
          cur_col <= '0;
          cur_row <= cur_row + AW'(1);
        end else begin
          cur_col <= cur_col + DW'(1);
        end
      end
    end
  end

  assign ef_prod = (FW+CLW)'(efr) * (FW+CLW)'(cfg.cell_width);
  assign nf_prod = (FW+CLW)'(nfr) * (FW+CLW)'(cfg.cell_height);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pe_cell <= (DW+CLW)'(hit_col) * (DW+CLW)'(cfg.cell_width);
      pn_cell <= (AW+CLW)'(hit_row) * (AW+CLW)'(cfg.cell_height);
      pe_frac <= ef_prod[FW+CLW-1:FW];
      pn_frac <= nf_prod[FW+CLW-1:FW];
    end
  end

  assign e_sum = {{(XW-OW){cfg.origin_east[OW-1]}}, cfg.origin_east} +
                 XW'(pe_cell) + XW'(pe_frac);
  assign n_sum = {{(XW-OW){cfg.origin_north[OW-1]}}, cfg.origin_north} +
                 XW'(pn_cell) + XW'(pn_frac);

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.zero_total = (total == '0);
  assign stat.hit        = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && stat.out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && stat.out_free) begin
      easting  <= err ? '0 : e_sum;
      northing <= err ? '0 : n_sum;
      status   <= err ? wgcs_pkg::STATUS_ZERO_TOTAL : wgcs_pkg::STATUS_OK;
    end
  end

endmodule
